### hdl/gcrc_pkg.sv
// Package for the great-circle range check: fixed constants, register indexes
// and the elaboration-time functions that build the CORDIC constant tables.
// No dependencies.
package gcrc_pkg;

  localparam int unsigned EARTH_RADIUS_M = 6371000;
  localparam int unsigned EARTH_RADIUS_W = 23;
  localparam logic [24:0] HALF_CIRC_M = 25'd20015087;
  localparam int unsigned DIST_W = 26;

  // Angle differences in 1e-7 degree units need 34 signed bits.
  localparam int unsigned DEG_W = 34;
  localparam logic signed [DEG_W-1:0] HALF_TURN = 34'sd1800000000;
  localparam logic signed [DEG_W-1:0] FULL_TURN = 34'sd3600000000;

  // Square root: radicand below 2^63, one result bit per cell.
  localparam int unsigned RAD_W = 63;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned VEC_W = 34;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  // pi/4 in Q60 by Machin's formula, truncated series.
  function automatic logic [63:0] quarter_pi_q60();
    logic [63:0] p5;
    logic [63:0] p239;
    logic [63:0] s5;
    logic [63:0] s239;
    p5 = (64'd1 << 60) / 64'd5;
    p239 = (64'd1 << 60) / 64'd239;
    s5 = '0;
    s239 = '0;
    for (int k = 0; k < 40; k++) begin
      if (p5 != 0) begin
        if (k % 2 == 1) s5 = s5 - p5 / 64'(2 * k + 1);
        else s5 = s5 + p5 / 64'(2 * k + 1);
        p5 = p5 / 64'd25;
      end
      if (p239 != 0) begin
        if (k % 2 == 1) s239 = s239 - p239 / 64'(2 * k + 1);
        else s239 = s239 + p239 / 64'(2 * k + 1);
        p239 = p239 / 64'd57121;
      end
    end
    return (s5 << 2) - s239;
  endfunction

  // atan(2^-i) rounded half up to the given number of fraction bits.
  function automatic logic [63:0] atan_qf(input int i, input int frac);
    logic [63:0] q;
    q = '0;
    if (i == 0) begin
      q = quarter_pi_q60();
    end else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 60) begin
          if (k % 2 == 1) q = q - (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
          else q = q + (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        end
      end
    end
    return (q + (64'd1 << (59 - frac))) >> (60 - frac);
  endfunction

  // Radians per 1e-7 degree of half angle, scaled by 2^62.
  function automatic logic [63:0] deg_scale();
    logic [63:0] pi4;
    pi4 = quarter_pi_q60() << 4;
    return (pi4 + 64'd1800000000) / 64'd3600000000;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = v_in;
    res = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Inverse CORDIC gain for the given iteration count, in the given fraction bits.
  function automatic logic [63:0] inv_gain(input int iters, input int frac);
    logic [63:0] prod;
    logic [63:0] root;
    logic [71:0] num;
    logic [71:0] rem;
    logic [71:0] quo;
    prod = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < iters) prod = prod + (prod >> (2 * i));
    end
    root = isqrt64(prod);
    num = 72'd1 << (frac + 30);
    // Restoring long division, one quotient bit per step.
    rem = '0;
    quo = '0;
    for (int b = 71; b >= 0; b--) begin
      rem = {rem[70:0], num[b]};
      if (rem >= {8'd0, root}) begin
        rem = rem - {8'd0, root};
        quo[b] = 1'b1;
      end
    end
    return quo[63:0];
  endfunction

endpackage

### hdl/great_circle_range_check.sv
// Throughput: one transaction per cycle; the whole pipeline of CORDIC, square root and
// multiplier cells advances together and holds while the output is stalled.
// Reset clears the pipeline valid bits, the output valid and the three configuration registers.
// Depends on gcrc_pkg, gcrc_rot_cell, gcrc_sqrt_cell and gcrc_vec_cell.
module great_circle_range_check #(
  parameter int unsigned CORDIC_ITERATIONS = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 30
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wen_i,
  input  logic [gcrc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gcrc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [30:0]                   vehicle_latitude_i,
  input  logic signed [31:0]                   vehicle_longitude_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [24:0]                          distance_metres_o,
  output logic                                 out_of_range_o
);

  localparam int unsigned N = CORDIC_ITERATIONS;
  localparam int unsigned F = ANGLE_FRAC_BITS;
  localparam int unsigned SW = F + 3;
  localparam int unsigned DW = gcrc_pkg::DEG_W;
  localparam int unsigned RW = gcrc_pkg::RAD_W;
  localparam int unsigned XW = gcrc_pkg::VEC_W;
  localparam int unsigned DEPTH = 2 * N + 40;
  localparam int unsigned PW = gcrc_pkg::EARTH_RADIUS_W + SW + 1;

  localparam logic [31:0] DegScale = 32'(gcrc_pkg::deg_scale());
  localparam logic signed [SW-1:0] InvGain = SW'(gcrc_pkg::inv_gain(N, F));
  localparam logic signed [SW-1:0] One = SW'(64'd1 << F);
  localparam logic [F:0] OneU = {1'b1, {F{1'b0}}};
  localparam logic [63:0] RoundTheta = 64'd1 << (61 - F);
  localparam logic [2*SW-1:0] HalfLsb = {{(2*SW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [PW-1:0] HalfLsbD = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [gcrc_pkg::EARTH_RADIUS_W-1:0] Radius =
    gcrc_pkg::EARTH_RADIUS_W'(gcrc_pkg::EARTH_RADIUS_M);

  // QF * QF -> QF, rounded half away from zero on the magnitude.
  function automatic logic signed [SW-1:0] mul_frac(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b);
    logic          neg;
    logic [SW-1:0] ma, mb;
    logic [2*SW-1:0] pr;
    logic [SW-1:0] m;
    neg = a[SW-1] ^ b[SW-1];
    ma = a[SW-1] ? SW'(-a) : SW'(a);
    mb = b[SW-1] ? SW'(-b) : SW'(b);
    pr = {{SW{1'b0}}, ma} * {{SW{1'b0}}, mb};
    m = SW'((pr + HalfLsb) >> F);
    return neg ? -signed'(m) : signed'(m);
  endfunction

  // Configuration registers.
  logic signed [30:0] node_lat_q;
  logic signed [31:0] node_lon_q;
  logic [24:0]        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_lat_q <= '0;
      node_lon_q <= '0;
      radius_q <= '0;
    end else if (cfg_wen_i) begin
      unique case (cfg_idx_i)
        gcrc_pkg::CFG_NODE_LAT: node_lat_q <= signed'(cfg_data_i[30:0]);
        gcrc_pkg::CFG_NODE_LON: node_lon_q <= signed'(cfg_data_i);
        gcrc_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: everything moves together unless the result is held.
  logic             adv;
  logic             in_acc;
  logic [DEPTH-1:0] vld_q;
  logic             out_valid_q;

  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_acc};
      out_valid_q <= vld_q[DEPTH-1];
    end
  end

  // Lanes: latitude difference, node latitude, vehicle latitude, longitude difference.
  logic signed [DW-1:0] d_d [4];
  logic signed [DW-1:0] d_q [4];
  logic [30:0]          absw_d [4];
  logic [30:0]          absw_q [4];
  logic signed [SW-1:0] theta_d [4];
  logic signed [SW-1:0] theta_q [4];

  always_comb begin
    d_d[0] = DW'(vehicle_latitude_i) - DW'(node_lat_q);
    d_d[1] = DW'(node_lat_q);
    d_d[2] = DW'(vehicle_latitude_i);
    d_d[3] = DW'(vehicle_longitude_i) - DW'(node_lon_q);
  end

  always_comb begin
    logic signed [DW-1:0] w;
    logic [63:0] prod;
    for (int l = 0; l < 4; l++) begin
      w = d_q[l];
      if (w >= gcrc_pkg::HALF_TURN) w = w - gcrc_pkg::FULL_TURN;
      else if (w < -gcrc_pkg::HALF_TURN) w = w + gcrc_pkg::FULL_TURN;
      absw_d[l] = w[DW-1] ? 31'(-w) : 31'(w);
      prod = {33'd0, absw_q[l]} * {32'd0, DegScale};
      theta_d[l] = signed'(SW'((prod + RoundTheta) >> (62 - F)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q <= d_d;
      absw_q <= absw_d;
      theta_q <= theta_d;
    end
  end

  // Four rotation chains give the half-angle sines.
  logic signed [SW-1:0] rot_x [4][N+1];
  logic signed [SW-1:0] rot_y [4][N+1];
  logic signed [SW-1:0] rot_z [4][N+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign rot_x[l][0] = InvGain;
    assign rot_y[l][0] = '0;
    assign rot_z[l][0] = theta_q[l];
    for (genvar i = 0; i < N; i++) begin : g_rot
      gcrc_rot_cell #(
        .W    (SW),
        .SHIFT(i),
        .ATAN (gcrc_pkg::atan_qf(i, F))
      ) u_rot (
        .clk_i(clk_i),
        .en_i (adv),
        .x_i  (rot_x[l][i]),
        .y_i  (rot_y[l][i]),
        .z_i  (rot_z[l][i]),
        .x_o  (rot_x[l][i+1]),
        .y_o  (rot_y[l][i+1]),
        .z_o  (rot_z[l][i+1])
      );
    end
  end

  // Haversine term a, one multiplication per stage.
  logic signed [SW-1:0] sq_d [4];
  logic signed [SW-1:0] sq_q [4];
  logic signed [SW-1:0] hlat2_q, hlon2_q, p_q, p_d;
  logic signed [SW-1:0] hlat3_q, q_q;
  logic signed [SW:0]   a_sum;
  logic [F:0]           a_d, a_q;

  always_comb begin
    logic signed [SW-1:0] cos1, cos2;
    for (int l = 0; l < 4; l++) begin
      sq_d[l] = mul_frac(rot_y[l][N], rot_y[l][N]);
    end
    cos1 = One - (sq_q[1] <<< 1);
    cos2 = One - (sq_q[2] <<< 1);
    p_d = mul_frac(cos1, cos2);
  end

  always_comb begin
    a_sum = (SW+1)'(hlat3_q) + (SW+1)'(q_q);
    if (a_sum[SW]) a_d = '0;
    else if (a_sum > (SW+1)'(One)) a_d = OneU;
    else a_d = a_sum[F:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= sq_d;
      hlat2_q <= sq_q[0];
      hlon2_q <= sq_q[3];
      p_q <= p_d;
      hlat3_q <= hlat2_q;
      q_q <= mul_frac(p_q, hlon2_q);
      a_q <= a_d;
    end
  end

  // Two square-root chains: root of a and root of 1 - a.
  logic [RW-1:0] sqa_v [gcrc_pkg::SQRT_STEPS+1];
  logic [RW-1:0] sqa_r [gcrc_pkg::SQRT_STEPS+1];
  logic [RW-1:0] sqb_v [gcrc_pkg::SQRT_STEPS+1];
  logic [RW-1:0] sqb_r [gcrc_pkg::SQRT_STEPS+1];

  assign sqa_v[0] = RW'(a_q) << (62 - F);
  assign sqb_v[0] = RW'(OneU - a_q) << (62 - F);
  assign sqa_r[0] = '0;
  assign sqb_r[0] = '0;

  for (genvar s = 0; s < gcrc_pkg::SQRT_STEPS; s++) begin : g_sqrt
    gcrc_sqrt_cell #(.STEP(s)) u_sqa (
      .clk_i(clk_i),
      .en_i (adv),
      .v_i  (sqa_v[s]),
      .r_i  (sqa_r[s]),
      .v_o  (sqa_v[s+1]),
      .r_o  (sqa_r[s+1])
    );
    gcrc_sqrt_cell #(.STEP(s)) u_sqb (
      .clk_i(clk_i),
      .en_i (adv),
      .v_i  (sqb_v[s]),
      .r_i  (sqb_r[s]),
      .v_o  (sqb_v[s+1]),
      .r_o  (sqb_r[s+1])
    );
  end

  // Vectoring chain gives atan2(sqrt(a), sqrt(1 - a)).
  logic signed [XW-1:0] vec_x [N+1];
  logic signed [XW-1:0] vec_y [N+1];
  logic signed [SW-1:0] vec_z [N+1];

  assign vec_x[0] = signed'({2'b00, sqb_r[gcrc_pkg::SQRT_STEPS][31:0]});
  assign vec_y[0] = signed'({2'b00, sqa_r[gcrc_pkg::SQRT_STEPS][31:0]});
  assign vec_z[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcrc_vec_cell #(
      .XW   (XW),
      .ZW   (SW),
      .SHIFT(i),
      .ATAN (gcrc_pkg::atan_qf(i, F))
    ) u_vec (
      .clk_i(clk_i),
      .en_i (adv),
      .x_i  (vec_x[i]),
      .y_i  (vec_y[i]),
      .z_i  (vec_z[i]),
      .x_o  (vec_x[i+1]),
      .y_o  (vec_y[i+1]),
      .z_o  (vec_z[i+1])
    );
  end

  // Central angle to metres, then saturation and the coverage compare.
  logic [SW:0]   c_ang;
  logic [PW-1:0] dprod;
  logic [gcrc_pkg::DIST_W-1:0] dist_d, dist_q;
  logic [24:0]   sat_d, dist_o_q;
  logic          oor_q;

  always_comb begin
    c_ang = vec_z[N][SW-1] ? '0 : {vec_z[N][SW-1:0], 1'b0};
    dprod = PW'(Radius) * PW'(c_ang);
    dist_d = gcrc_pkg::DIST_W'((dprod + HalfLsbD) >> F);
    if (dist_q > gcrc_pkg::DIST_W'(gcrc_pkg::HALF_CIRC_M)) sat_d = gcrc_pkg::HALF_CIRC_M;
    else sat_d = dist_q[24:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      dist_o_q <= sat_d;
      oor_q <= sat_d > radius_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_metres_o = dist_o_q;
  assign out_of_range_o = oor_q;

  a_dist_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_metres_o <= gcrc_pkg::HALF_CIRC_M)
    else $error("distance above half circumference");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline moved while output stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_valid_i |=> !vld_q[0])
    else $error("item entered without an input transaction");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !vld_q[DEPTH-1] |=> !out_valid_o)
    else $error("result appeared without a pipeline item");

endmodule

### hdl/gcrc_rot_cell.sv
// One rotation-mode CORDIC cell: a fixed shift and arctangent constant.
// Uses no package items; instantiated in chains by the top level.
module gcrc_rot_cell #(
  parameter int unsigned W = 33,
  parameter int unsigned SHIFT = 0,
  parameter logic [63:0] ATAN = 64'd0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o
);

  localparam logic signed [W-1:0] AtanC = W'(ATAN);

  logic signed [W-1:0] x_d, y_d, z_d;
  logic signed [W-1:0] x_q, y_q, z_q;
  logic signed [W-1:0] xs, ys;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!z_i[W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - AtanC;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + AtanC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### hdl/gcrc_vec_cell.sv
// One vectoring-mode CORDIC cell that drives y toward zero and sums the angle.
// Uses no package items; instantiated in a chain by the top level.
module gcrc_vec_cell #(
  parameter int unsigned XW = 34,
  parameter int unsigned ZW = 33,
  parameter int unsigned SHIFT = 0,
  parameter logic [63:0] ATAN = 64'd0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] AtanC = ZW'(ATAN);

  logic signed [XW-1:0] x_d, y_d, x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_d, z_q;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + AtanC;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - AtanC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### hdl/gcrc_sqrt_cell.sv
// One step of the digit-by-digit integer square root, one result bit per cell.
// Depends on gcrc_pkg for the radicand width.
module gcrc_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gcrc_pkg::RAD_W-1:0]    v_i,
  input  logic [gcrc_pkg::RAD_W-1:0]    r_i,
  output logic [gcrc_pkg::RAD_W-1:0]    v_o,
  output logic [gcrc_pkg::RAD_W-1:0]    r_o
);

  localparam int unsigned RW = gcrc_pkg::RAD_W;
  localparam logic [RW-1:0] BitC = {{(RW-1){1'b0}}, 1'b1} << (RW - 1 - 2 * STEP);

  logic [RW:0]   trial;
  logic [RW-1:0] v_d, r_d, v_q, r_q;

  always_comb begin
    trial = {1'b0, r_i} + {1'b0, BitC};
    if ({1'b0, v_i} >= trial) begin
      v_d = v_i - trial[RW-1:0];
      r_d = (r_i >> 1) + BitC;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule
